[design/toy_cpu_execute_unit_defines.svh]
// Assertion macros shared by the execute unit RTL.
// Depends on nothing; the including module must provide clk_i and rst_ni.
`ifndef TOY_CPU_EXECUTE_UNIT_DEFINES_SVH
`define TOY_CPU_EXECUTE_UNIT_DEFINES_SVH

// Concurrent assertion on the rising clock edge, off while reset is held.
`define TCPU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same check written as an overlapping implication.
`define TCPU_ASSERT_IMPL(lbl, ante, cons, msg) \
  `TCPU_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

[design/tcpu_pkg.sv]
// Shared types and constants of the toy CPU execute unit.
// Used by tcpu_exec, tcpu_state and the top level; depends on nothing.
package tcpu_pkg;

  localparam int unsigned DATA_W        = 8;
  localparam int unsigned REG_IDX_W     = 2;
  localparam int unsigned OP_W          = 4;
  localparam int unsigned MEM_WORDS_DEF = 32;

  // Register file contents right after reset, entry 0 in the lowest byte.
  localparam logic [3:0][DATA_W-1:0] REG_RESET = {8'd10, 8'd9, 8'd4, 8'd0};

  // Value a load returns when its address lies outside the memory.
  localparam logic [DATA_W-1:0] LOAD_FAIL = 8'hFF;

  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 4'd0,
    OP_SUB    = 4'd1,
    OP_LOAD   = 4'd2,
    OP_STORE  = 4'd3,
    OP_INPUT  = 4'd4,
    OP_OUTPUT = 4'd5,
    OP_JUMP   = 4'd6,
    OP_CALL   = 4'd7,
    OP_RET    = 4'd8
  } opcode_e;

  typedef struct packed {
    logic [DATA_W-1:0]    in_value;
    logic [REG_IDX_W-1:0] src_reg;
    logic [REG_IDX_W-1:0] dest_reg;
    logic [OP_W-1:0]      opcode;
  } item_t;

  typedef struct packed {
    logic              mem_error;
    logic [DATA_W-1:0] out_value;
    logic              out_valid;
    logic [DATA_W-1:0] next_pc;
  } result_t;

  // State update produced by the execute logic for one instruction.
  // The memory address is 8 bits wide, enough for the largest memory.
  typedef struct packed {
    logic                 reg_we;
    logic [REG_IDX_W-1:0] reg_idx;
    logic [DATA_W-1:0]    reg_wdata;
    logic                 mem_we;
    logic [DATA_W-1:0]    mem_addr;
    logic [DATA_W-1:0]    mem_wdata;
    logic [DATA_W-1:0]    pc_next;
  } wr_t;

endpackage

[design/toy_cpu_execute_unit.sv]
// Top level of the toy CPU execute unit: stream ports, input and result
// registers around tcpu_exec and tcpu_state. Depends on tcpu_pkg.
//
// Usage: each item on the slave stream (s_axis_*) is one decoded
// instruction. The unit keeps an 8-bit program counter, four 8-bit
// registers and a data memory of MEM_WORDS bytes, and returns exactly one
// result item per instruction on the master stream (m_axis_*).
// An accepted item lands in the input register. The execute logic then
// reads the state, updates it and loads the result register as soon as
// the result register is free or is being emptied.
// Throughput is one item per clock cycle while the receiver does not stall;
// the single pass through the execute logic between the input and result
// registers sets that figure, and a dependent instruction may follow directly
// since state is written at the same edge the result is captured.
// When the receiver stalls, the result register holds its item and the
// input register can still take one more item; only when both are full
// does s_axis_tready drop. No result is lost or repeated.
// Reset (rst_ni low, asynchronous) empties both registers, clears the
// program counter and the data memory, and loads the registers with
// 0, 4, 9 and 10. The unit accepts items as soon as reset is released.
`include "toy_cpu_execute_unit_defines.svh"

module toy_cpu_execute_unit #(
  parameter int unsigned MEM_WORDS = tcpu_pkg::MEM_WORDS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [3:0] opcode, [5:4] dest_reg, [7:6] src_reg, [15:8] in_value
  input  logic [15:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] next_pc, [8] out_valid, [16:9] out_value, [17] mem_error,
  // [23:18] zero
  output logic [23:0] m_axis_tdata
);
  import tcpu_pkg::*;

  // Input register holding the instruction under execution.
  logic    in_valid_q;
  item_t   item_q;
  // Result register driving the master stream.
  logic    out_valid_q;
  result_t res_q;

  logic    exec_fire;
  wr_t     wr;
  result_t res;

  logic [DATA_W-1:0] pc;
  logic [DATA_W-1:0] dst_val;
  logic [DATA_W-1:0] src_val;
  logic [DATA_W-1:0] load_data;
  logic [DATA_W-1:0] ret_pc;

  // The held instruction executes whenever the result register is free or
  // is being emptied in the same cycle.
  assign exec_fire     = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || exec_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid_q <= 1'b1;
    end else if (exec_fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item_q <= item_t'(s_axis_tdata);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (exec_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_fire) begin
      res_q <= res;
    end
  end

  tcpu_state #(
    .MEM_WORDS (MEM_WORDS)
  ) u_state (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .upd_en_i    (exec_fire),
    .wr_i        (wr),
    .dest_idx_i  (item_q.dest_reg),
    .src_idx_i   (item_q.src_reg),
    .pc_o        (pc),
    .dst_val_o   (dst_val),
    .src_val_o   (src_val),
    .load_data_o (load_data),
    .ret_pc_o    (ret_pc)
  );

  tcpu_exec #(
    .MEM_WORDS (MEM_WORDS)
  ) u_exec (
    .item_i      (item_q),
    .pc_i        (pc),
    .src_val_i   (src_val),
    .dst_val_i   (dst_val),
    .load_data_i (load_data),
    .ret_pc_i    (ret_pc),
    .wr_o        (wr),
    .res_o       (res)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, res_q.mem_error, res_q.out_value, res_q.out_valid,
                          res_q.next_pc};

  // A result only appears after an instruction sat in the input register.
  `TCPU_ASSERT_IMPL(a_result_from_item, $rose(out_valid_q), $past(in_valid_q),
                    "result register loaded without a held instruction")

  // A held instruction that cannot execute stays in place.
  `TCPU_ASSERT(a_item_kept, (in_valid_q && !exec_fire) |=> (in_valid_q && $stable(item_q)),
               "stalled instruction was dropped or overwritten")

  // An empty input register always takes a new item.
  `TCPU_ASSERT_IMPL(a_ready_when_empty, !in_valid_q, s_axis_tready,
                    "input stage empty but not ready")

  // A jump leaves the counter at the source register value.
  `TCPU_ASSERT(a_jump_target,
               (exec_fire && item_q.opcode == OP_JUMP) |=> (pc == $past(src_val)),
               "program counter does not match jump target")

endmodule

[design/tcpu_exec.sv]
// Combinational execute logic: decodes one instruction and forms the
// state update and the result item. Depends on tcpu_pkg.
module tcpu_exec #(
  parameter int unsigned MEM_WORDS = tcpu_pkg::MEM_WORDS_DEF
) (
  input  tcpu_pkg::item_t               item_i,
  input  logic [tcpu_pkg::DATA_W-1:0]   pc_i,
  input  logic [tcpu_pkg::DATA_W-1:0]   src_val_i,
  input  logic [tcpu_pkg::DATA_W-1:0]   dst_val_i,
  input  logic [tcpu_pkg::DATA_W-1:0]   load_data_i,
  input  logic [tcpu_pkg::DATA_W-1:0]   ret_pc_i,
  output tcpu_pkg::wr_t                 wr_o,
  output tcpu_pkg::result_t             res_o
);
  import tcpu_pkg::*;

  localparam logic [DATA_W:0]   MemWordsW = (DATA_W+1)'(MEM_WORDS);
  localparam logic [DATA_W-1:0] RetSlot   = DATA_W'(MEM_WORDS - 1);

  logic [DATA_W-1:0] pc_inc;
  logic              in_range;

  assign pc_inc   = pc_i + 8'd1;
  assign in_range = {1'b0, src_val_i} < MemWordsW;

  always_comb begin
    wr_o           = '0;
    wr_o.reg_idx   = item_i.dest_reg;
    wr_o.mem_addr  = src_val_i;
    wr_o.mem_wdata = dst_val_i;
    wr_o.pc_next   = pc_inc;
    res_o          = '0;
    case (opcode_e'(item_i.opcode))
      OP_ADD: begin
        wr_o.reg_we    = 1'b1;
        wr_o.reg_wdata = dst_val_i + src_val_i;
      end
      OP_SUB: begin
        wr_o.reg_we    = 1'b1;
        wr_o.reg_wdata = dst_val_i - src_val_i;
      end
      OP_LOAD: begin
        wr_o.reg_we    = 1'b1;
        wr_o.reg_wdata = in_range ? load_data_i : LOAD_FAIL;
        res_o.mem_error = !in_range;
      end
      OP_STORE: begin
        wr_o.mem_we     = in_range;
        res_o.mem_error = !in_range;
      end
      OP_INPUT: begin
        wr_o.reg_we    = 1'b1;
        wr_o.reg_wdata = item_i.in_value;
      end
      OP_OUTPUT: begin
        res_o.out_valid = 1'b1;
        res_o.out_value = dst_val_i;
      end
      OP_JUMP: begin
        wr_o.pc_next = src_val_i;
      end
      OP_CALL: begin
        // The return address is the already advanced counter.
        wr_o.mem_we    = 1'b1;
        wr_o.mem_addr  = RetSlot;
        wr_o.mem_wdata = pc_inc;
        wr_o.pc_next   = src_val_i;
      end
      OP_RET: begin
        wr_o.pc_next = ret_pc_i;
      end
      default: begin
        // Unknown opcodes clear the destination register.
        wr_o.reg_we    = 1'b1;
        wr_o.reg_wdata = '0;
      end
    endcase
    res_o.next_pc = wr_o.pc_next;
  end

endmodule

[design/tcpu_state.sv]
// Architectural state: program counter, four-entry register file and the
// data memory, with their read ports. Depends on tcpu_pkg.
module tcpu_state #(
  parameter int unsigned MEM_WORDS = tcpu_pkg::MEM_WORDS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               upd_en_i,
  input  tcpu_pkg::wr_t                      wr_i,
  input  logic [tcpu_pkg::REG_IDX_W-1:0]     dest_idx_i,
  input  logic [tcpu_pkg::REG_IDX_W-1:0]     src_idx_i,
  output logic [tcpu_pkg::DATA_W-1:0]        pc_o,
  output logic [tcpu_pkg::DATA_W-1:0]        dst_val_o,
  output logic [tcpu_pkg::DATA_W-1:0]        src_val_o,
  output logic [tcpu_pkg::DATA_W-1:0]        load_data_o,
  output logic [tcpu_pkg::DATA_W-1:0]        ret_pc_o
);
  import tcpu_pkg::*;

  localparam int unsigned AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;

  logic [DATA_W-1:0]       pc_q;
  logic [3:0][DATA_W-1:0]  rf_q;
  logic [DATA_W-1:0]       mem_q [MEM_WORDS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= '0;
      rf_q <= REG_RESET;
      for (int i = 0; i < MEM_WORDS; i++) begin
        mem_q[i] <= '0;
      end
    end else if (upd_en_i) begin
      pc_q <= wr_i.pc_next;
      if (wr_i.reg_we) begin
        rf_q[wr_i.reg_idx] <= wr_i.reg_wdata;
      end
      if (wr_i.mem_we) begin
        mem_q[wr_i.mem_addr[AW-1:0]] <= wr_i.mem_wdata;
      end
    end
  end

  assign pc_o        = pc_q;
  assign dst_val_o   = rf_q[dest_idx_i];
  assign src_val_o   = rf_q[src_idx_i];
  // Only used when the address is in range; the caller checks that.
  assign load_data_o = mem_q[src_val_o[AW-1:0]];
  assign ret_pc_o    = mem_q[MEM_WORDS-1];

endmodule

[bench/tb_toy_cpu_execute_unit.sv]
// Self-checking testbench for toy_cpu_execute_unit: directed instruction table, then
// random instruction sequences, each result checked against a built-in execute predictor.
// Depends on tcpu_pkg and the toy_cpu_execute_unit RTL.
module tb_toy_cpu_execute_unit;
  import tcpu_pkg::*;

  localparam int unsigned MEM_DEPTH    = MEM_WORDS_DEF;
  localparam int unsigned RANDOM_ITEMS = 650;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  // Opcodes above RET have no function and clear the destination register.
  localparam logic [OP_W-1:0] OP_UNKNOWN_LO = 4'd9;
  localparam logic [OP_W-1:0] OP_UNKNOWN_HI = 4'd15;

  typedef struct {
    item_t   instr;
    bit      typed;
    result_t want;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;

  // Architectural state as the predictor sees it.
  logic [DATA_W-1:0] model_pc;
  logic [DATA_W-1:0] model_regs [4];
  logic [DATA_W-1:0] model_mem  [MEM_DEPTH];

  result_t  expected_results [$];
  dir_row_t directed_rows [$];
  item_t    planned_instrs [$];

  bit          calm_phase = 1'b0;
  int unsigned mismatches = 0;
  int unsigned sent_count = 0;
  int unsigned checked_count = 0;
  int unsigned fault_count = 0;
  int unsigned output_count = 0;
  int unsigned cycle_count = 0;

  toy_cpu_execute_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("toy_cpu_execute_unit verification failed");
      $finish;
    end
  end

  // Mostly back-to-back, sometimes a short pause, rarely a long one.
  function automatic int pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic reset_model();
    model_pc = '0;
    for (int i = 0; i < 4; i++) model_regs[i] = REG_RESET[i];
    for (int i = 0; i < MEM_DEPTH; i++) model_mem[i] = '0;
  endtask

  // Executes one instruction on the predictor state and returns its result.
  function automatic result_t execute_model(item_t instr);
    logic [DATA_W-1:0] addr;
    logic [DATA_W-1:0] dval;
    result_t           res;
    addr = model_regs[instr.src_reg];
    dval = model_regs[instr.dest_reg];
    res = '0;
    model_pc = model_pc + 8'd1;
    case (instr.opcode)
      OP_ADD: model_regs[instr.dest_reg] = dval + addr;
      OP_SUB: model_regs[instr.dest_reg] = dval - addr;
      OP_LOAD: begin
        if (addr < MEM_DEPTH) begin
          model_regs[instr.dest_reg] = model_mem[addr];
        end else begin
          model_regs[instr.dest_reg] = LOAD_FAIL;
          res.mem_error = 1'b1;
        end
      end
      OP_STORE: begin
        if (addr < MEM_DEPTH) model_mem[addr] = dval;
        else res.mem_error = 1'b1;
      end
      OP_INPUT: model_regs[instr.dest_reg] = instr.in_value;
      OP_OUTPUT: begin
        res.out_valid = 1'b1;
        res.out_value = dval;
      end
      OP_JUMP: model_pc = addr;
      OP_CALL: begin
        // The return address is the already advanced counter.
        model_mem[MEM_DEPTH-1] = model_pc;
        model_pc = addr;
      end
      OP_RET: model_pc = model_mem[MEM_DEPTH-1];
      default: model_regs[instr.dest_reg] = '0;
    endcase
    res.next_pc = model_pc;
    return res;
  endfunction

  function automatic item_t make_instr(logic [OP_W-1:0] op, int dst, int src, int val);
    item_t instr;
    instr.opcode   = op;
    instr.dest_reg = dst[REG_IDX_W-1:0];
    instr.src_reg  = src[REG_IDX_W-1:0];
    instr.in_value = val[DATA_W-1:0];
    return instr;
  endfunction

  task automatic add_row(logic [OP_W-1:0] op, int dst, int src, int val, bit typed = 1'b0,
                         int pc = 0, bit ov = 1'b0, int oval = 0, bit err = 1'b0);
    dir_row_t row;
    row.instr           = make_instr(op, dst, src, val);
    row.typed           = typed;
    row.want.next_pc    = pc[DATA_W-1:0];
    row.want.out_valid  = ov;
    row.want.out_value  = oval[DATA_W-1:0];
    row.want.mem_error  = err;
    directed_rows = {directed_rows, row};
  endtask

  // Drives one instruction and records what it should produce once accepted.
  task automatic issue_instr(item_t instr, bit typed, result_t want);
    int      gap;
    result_t predicted;
    gap = calm_phase ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= instr;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predicted = execute_model(instr);
    if (typed) predicted = want;
    expected_results = {expected_results, predicted};
    fault_count  += predicted.mem_error;
    output_count += predicted.out_valid;
    sent_count++;
    @(negedge clk_i);
  endtask

  // Queues one short, mostly well-formed instruction sequence.
  task automatic plan_sequence();
    int unsigned     kind;
    int              areg;
    int              addr;
    logic [OP_W-1:0] op;
    kind = $urandom_range(0, 99);
    areg = $urandom_range(0, 3);
    if (kind < 12) begin
      // Noise: every field random, unknown opcodes included.
      planned_instrs = {planned_instrs, item_t'(16'($urandom))};
    end else if (kind < 40) begin
      // Address setup, then loads and stores through it; some addresses fault.
      addr = ($urandom_range(0, 9) == 0) ? $urandom_range(MEM_DEPTH, 255)
                                         : $urandom_range(0, MEM_DEPTH - 1);
      planned_instrs = {planned_instrs, make_instr(OP_INPUT, areg, $urandom, addr)};
      repeat ($urandom_range(1, 3)) begin
        planned_instrs = {planned_instrs,
                          make_instr($urandom_range(0, 1) ? OP_LOAD : OP_STORE,
                                     $urandom, areg, $urandom)};
      end
      planned_instrs = {planned_instrs, make_instr(OP_OUTPUT, $urandom, $urandom, $urandom)};
    end else if (kind < 55) begin
      // Subroutine call with a little work inside, then return.
      planned_instrs = {planned_instrs, make_instr(OP_INPUT, areg, $urandom, $urandom)};
      planned_instrs = {planned_instrs, make_instr(OP_CALL, $urandom, areg, $urandom)};
      repeat ($urandom_range(0, 3)) begin
        planned_instrs = {planned_instrs,
                          make_instr($urandom_range(0, 1) ? OP_ADD : OP_SUB,
                                     $urandom, $urandom, $urandom)};
      end
      planned_instrs = {planned_instrs, make_instr(OP_RET, $urandom, $urandom, $urandom)};
    end else if (kind < 65) begin
      planned_instrs = {planned_instrs, make_instr(OP_INPUT, areg, $urandom, $urandom)};
      planned_instrs = {planned_instrs, make_instr(OP_JUMP, $urandom, areg, $urandom)};
    end else begin
      repeat ($urandom_range(1, 4)) begin
        op = OP_W'($urandom_range(OP_ADD, OP_OUTPUT));
        if (op == OP_LOAD) op = OP_OUTPUT;
        planned_instrs = {planned_instrs, make_instr(op, $urandom, $urandom, $urandom)};
      end
    end
  endtask

  // Result side: random back-pressure, none during calm phases.
  initial begin
    int stall_left;
    stall_left = 0;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
        stall_left = calm_phase ? 0 : pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[$bits(result_t)-1:0];
      if (expected_results.size() == 0) begin
        $error("unexpected result item 0x%06h", m_axis_tdata);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        checked_count++;
        if (got.next_pc !== want.next_pc) begin
          $error("next_pc: expected %0d, got %0d", want.next_pc, got.next_pc);
          mismatches++;
        end
        if (got.out_valid !== want.out_valid) begin
          $error("out_valid: expected %0d, got %0d", want.out_valid, got.out_valid);
          mismatches++;
        end
        if (got.out_value !== want.out_value) begin
          $error("out_value: expected %0d, got %0d", want.out_value, got.out_value);
          mismatches++;
        end
        if (got.mem_error !== want.mem_error) begin
          $error("mem_error: expected %0d, got %0d", want.mem_error, got.mem_error);
          mismatches++;
        end
        if (m_axis_tdata[23:$bits(result_t)] !== '0) begin
          $error("pad: expected 0, got 0x%0h", m_axis_tdata[23:$bits(result_t)]);
          mismatches++;
        end
      end
    end
  end

  initial begin
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    reset_model();

    // Registers start at 0, 4, 9, 10 and the counter at 0.
    add_row(OP_OUTPUT, 3, 0, 0, 1'b1, 1, 1'b1, 10, 1'b0);
    add_row(OP_ADD, 1, 3, 0);
    add_row(OP_OUTPUT, 1, 0, 0);
    add_row(OP_INPUT, 0, 0, 255);
    add_row(OP_ADD, 0, 0, 0);            // 255 + 255 wraps
    add_row(OP_SUB, 3, 0, 0);            // 10 - 254 wraps
    add_row(OP_OUTPUT, 3, 0, 0);
    // Register 0 holds 254: both memory accesses fault.
    add_row(OP_LOAD, 2, 0, 0, 1'b1, 8, 1'b0, 0, 1'b1);
    add_row(OP_STORE, 1, 0, 0, 1'b1, 9, 1'b0, 0, 1'b1);
    add_row(OP_INPUT, 0, 0, MEM_DEPTH - 1);
    add_row(OP_STORE, 1, 0, 0);          // overwrite the return slot
    add_row(OP_RET, 0, 0, 0);
    add_row(OP_INPUT, 2, 0, 0);
    add_row(OP_STORE, 3, 2, 0);
    add_row(OP_LOAD, 1, 2, 0);
    add_row(OP_INPUT, 0, 0, MEM_DEPTH);  // first address past the end
    add_row(OP_LOAD, 1, 0, 0);
    add_row(OP_CALL, 0, 3, 0);
    add_row(OP_OUTPUT, 0, 0, 0);
    add_row(OP_RET, 0, 0, 0);
    add_row(OP_INPUT, 3, 0, 255);
    add_row(OP_JUMP, 0, 3, 0, 1'b1, 255, 1'b0, 0, 1'b0);
    // Counter wraps to 0; the unknown opcode clears register 3.
    add_row(OP_UNKNOWN_HI, 3, 0, 0, 1'b1, 0, 1'b0, 0, 1'b0);
    add_row(OP_UNKNOWN_LO, 1, 2, 0);
    add_row(OP_OUTPUT, 3, 0, 0);

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_rows[i]) begin
      issue_instr(directed_rows[i].instr, directed_rows[i].typed, directed_rows[i].want);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 60 == 0) calm_phase = ($urandom_range(0, 3) == 0);
      if (planned_instrs.size() == 0) plan_sequence();
      issue_instr(planned_instrs.pop_front(), 1'b0, '0);
    end
    s_axis_tvalid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Ran %0d instructions (%0d directed), checked %0d results.",
             sent_count, directed_rows.size(), checked_count);
    $display("Results included %0d address faults and %0d emitted values.",
             fault_count, output_count);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("toy_cpu_execute_unit verification clean");
    end else begin
      $display("toy_cpu_execute_unit verification failed");
    end
    $finish;
  end

endmodule
